// ===== src/assert_macros.svh =====
// Assertion macros for the splitter RTL.
// Depends on nothing; checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLRS_ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");
`define DLRS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
`define DLRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define DLRS_ASSERT_ALWAYS(name, clk, rst_n, cond)
`define DLRS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define DLRS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/dlrs_pkg.sv =====
// Shared types, codes and helper functions of the record splitter.
// Depends on nothing; every other RTL file imports it.
package dlrs_pkg;

	localparam int KEY_BYTES_DEF = 16;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;
	localparam int CMDQ_DEPTH    = 2;
	localparam int RESQ_DEPTH    = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;

	localparam logic [4:0] KEY_LENGTH_RESET = 5'd1;
	localparam logic [7:0] BACKSLASH        = 8'h5C;
	localparam logic [7:0] CHAR_SPACE       = 8'h20;
	localparam logic [7:0] CHAR_TAB         = 8'h09;
	localparam logic [7:0] CHAR_CR          = 8'h0D;

	typedef enum logic [2:0] {
		KIND_NAME_BYTE  = 3'd0,
		KIND_NAME_END   = 3'd1,
		KIND_BODY_BYTE  = 3'd2,
		KIND_RECORD_END = 3'd3,
		KIND_STREAM_END = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_DROP,
		PH_SKIP,
		PH_NAME,
		PH_BODY
	} phase_t;

	// Back-end sequencer: SEG_NEW means the head command has not been started.
	typedef enum logic [1:0] {
		SEG_NEW,
		SEG_LEAD,
		SEG_POPS,
		SEG_TAIL
	} seg_t;

	// Fixed part of a command: an optional leading marker or name byte and
	// an optional closing marker; window bytes travel beside it.
	typedef struct packed {
		logic       lead_valid;
		kind_t      lead_kind;
		logic [7:0] lead_byte;
		logic       lead_dir;
		logic       tail_valid;
		kind_t      tail_kind;
	} cmd_ctl_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       dir;
		logic       last;
	} result_t;

	typedef struct packed {
		logic res_push;
		logic res_last;
		logic res_full;
	} back_stat_t;

	// Space, tab, line feed, vertical tab, form feed and carriage return.
	function automatic logic is_space(input logic [7:0] b);
		return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

	// Key byte j; bytes from sixteen onwards read as zero.
	function automatic logic [7:0] key_byte(input logic [CFG_DATA_W-1:0] lo,
			input logic [CFG_DATA_W-1:0] hi, input logic [4:0] j);
		logic [7:0] r;
		if (j[4]) begin
			r = 8'h00;
		end else if (j[3]) begin
			r = hi[{j[2:0], 3'b000} +: 8];
		end else begin
			r = lo[{j[2:0], 3'b000} +: 8];
		end
		return r;
	endfunction

endpackage

// ===== src/dlrs_front.sv =====
// Front end: configuration registers, record phase tracking and the key window.
// Turns each accepted beat into at most one command. Depends on dlrs_pkg.
module dlrs_front import dlrs_pkg::*; #(
	parameter int KeyBytes = KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_take,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_stream,
	output logic                          cmd_push,
	output cmd_ctl_t                      cmd_ctl,
	output logic [KeyBytes:0][7:0]        cmd_seq,
	output logic [$clog2(KeyBytes+1)-1:0] cmd_start,
	output logic [$clog2(KeyBytes+1)-1:0] cmd_count
);

	localparam int CW = $clog2(KeyBytes + 1);

	phase_t                    phase_q, phase_d;
	logic [KeyBytes-1:0][7:0]  win_q;
	logic [CW-1:0]             fill_q, fill_d;
	logic [7:0]                lnb_q, lnb_d;
	logic [4:0]                key_length_q;
	logic [CFG_DATA_W-1:0]     key_low_q;
	logic [CFG_DATA_W-1:0]     key_high_q;

	logic [4:0]                len5;
	logic [CW-1:0]             eff_len;
	logic [CW:0]               fill_inc;
	logic [CW:0]               offs;
	logic                      over;
	logic [CW-1:0]             pop_cnt;
	logic [CW-1:0]             fill_after;
	logic                      key_hit;
	logic                      win_shift;
	logic [KeyBytes:0][7:0]    seq;

	// Window bytes oldest first at the low end, the incoming byte on top.
	assign seq       = {data_byte, win_q};
	assign cmd_seq   = seq;
	assign cmd_start = CW'(KeyBytes) - fill_q;

	// Effective key length, clamped to one and to the window depth.
	always_comb begin
		len5 = (key_length_q == 5'd0) ? 5'd1 : key_length_q;
		eff_len = (int'(len5) > KeyBytes) ? CW'(KeyBytes) : CW'(len5);
	end

	// Overflow count and parallel key compare over the newest bytes.
	always_comb begin
		fill_inc   = (CW+1)'(fill_q) + (CW+1)'(1);
		over       = fill_inc > (CW+1)'(eff_len);
		pop_cnt    = over ? CW'(fill_inc - (CW+1)'(eff_len)) : '0;
		fill_after = over ? eff_len : CW'(fill_inc);
		offs       = (CW+1)'(KeyBytes + 1) - (CW+1)'(eff_len);
		key_hit    = fill_inc >= (CW+1)'(eff_len);
		for (int p = 1; p <= KeyBytes; p++) begin
			if ((CW+1)'(p) >= offs) begin
				if (seq[p] != key_byte(key_low_q, key_high_q, 5'((CW+1)'(p) - offs))) begin
					key_hit = 1'b0;
				end
			end
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (in_take) begin
			if (end_of_stream) begin
				phase_d = PH_DROP;
			end else begin
				case (phase_q)
					PH_DROP: phase_d = PH_SKIP;
					PH_SKIP: begin
						if (!is_space(data_byte)) phase_d = PH_NAME;
					end
					PH_NAME: begin
						if (is_space(data_byte)) phase_d = PH_BODY;
					end
					PH_BODY: begin
						if (key_hit) phase_d = PH_DROP;
					end
					default: phase_d = PH_DROP;
				endcase
			end
		end
	end

	// Command for the back end, and the window bookkeeping that goes with it.
	always_comb begin
		cmd_ctl   = '{lead_valid: 1'b0, lead_kind: KIND_NAME_BYTE, lead_byte: 8'h00,
			lead_dir: 1'b0, tail_valid: 1'b0, tail_kind: KIND_STREAM_END};
		cmd_count = '0;
		fill_d    = fill_q;
		lnb_d     = lnb_q;
		win_shift = 1'b0;
		if (in_take) begin
			if (end_of_stream) begin
				cmd_ctl.tail_valid = 1'b1;
				cmd_ctl.tail_kind  = KIND_STREAM_END;
				if (phase_q == PH_NAME) begin
					cmd_ctl.lead_valid = 1'b1;
					cmd_ctl.lead_kind  = KIND_NAME_END;
					cmd_ctl.lead_dir   = (lnb_q == BACKSLASH);
				end
				if (phase_q == PH_BODY) begin
					cmd_count = fill_q;
				end
				fill_d = '0;
				lnb_d  = 8'h00;
			end else begin
				case (phase_q)
					PH_SKIP: begin
						if (!is_space(data_byte)) begin
							cmd_ctl.lead_valid = 1'b1;
							cmd_ctl.lead_kind  = KIND_NAME_BYTE;
							cmd_ctl.lead_byte  = data_byte;
							lnb_d              = data_byte;
						end
					end
					PH_NAME: begin
						cmd_ctl.lead_valid = 1'b1;
						if (is_space(data_byte)) begin
							cmd_ctl.lead_kind = KIND_NAME_END;
							cmd_ctl.lead_dir  = (lnb_q == BACKSLASH);
							fill_d            = '0;
						end else begin
							cmd_ctl.lead_kind = KIND_NAME_BYTE;
							cmd_ctl.lead_byte = data_byte;
							lnb_d             = data_byte;
						end
					end
					PH_BODY: begin
						win_shift = 1'b1;
						cmd_count = pop_cnt;
						fill_d    = fill_after;
						if (key_hit) begin
							cmd_ctl.tail_valid = 1'b1;
							cmd_ctl.tail_kind  = KIND_RECORD_END;
							fill_d             = '0;
							lnb_d              = 8'h00;
						end
					end
					default: ;
				endcase
			end
		end
		cmd_push = cmd_ctl.lead_valid || cmd_ctl.tail_valid || (cmd_count != '0);
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DROP;
			fill_q       <= '0;
			lnb_q        <= 8'h00;
			key_length_q <= KEY_LENGTH_RESET;
			key_low_q    <= '0;
			key_high_q   <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			lnb_q   <= lnb_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_KEY_LENGTH: key_length_q <= cfg_data[4:0];
					REG_KEY_LOW:    key_low_q    <= cfg_data;
					REG_KEY_HIGH:   key_high_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Window shift register; entries beyond the fill count never affect a result.
	always_ff @(posedge clk) begin
		if (win_shift) begin
			win_q <= seq[KeyBytes:1];
		end
	end

endmodule

// ===== src/dlrs_cmdq.sv =====
// Short command queue between the front end and the back end.
// Depends on dlrs_pkg for the command control type and depth.
module dlrs_cmdq import dlrs_pkg::*; #(
	parameter int KeyBytes = KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  cmd_ctl_t                      wr_ctl,
	input  logic [KeyBytes:0][7:0]        wr_seq,
	input  logic [$clog2(KeyBytes+1)-1:0] wr_start,
	input  logic [$clog2(KeyBytes+1)-1:0] wr_count,
	input  logic                          rd_en,
	output cmd_ctl_t                      rd_ctl,
	output logic [KeyBytes:0][7:0]        rd_seq,
	output logic [$clog2(KeyBytes+1)-1:0] rd_start,
	output logic [$clog2(KeyBytes+1)-1:0] rd_count,
	output logic                          full,
	output logic                          empty
);

	localparam int CW = $clog2(KeyBytes + 1);
	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int NW = $clog2(CMDQ_DEPTH + 1);

	cmd_ctl_t                 ctl_mem   [CMDQ_DEPTH];
	logic [KeyBytes:0][7:0]   seq_mem   [CMDQ_DEPTH];
	logic [CW-1:0]            start_mem [CMDQ_DEPTH];
	logic [CW-1:0]            count_mem [CMDQ_DEPTH];
	logic [PW-1:0]            wptr_q, rptr_q;
	logic [NW-1:0]            cnt_q;

	assign full     = (cnt_q == NW'(CMDQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign rd_ctl   = ctl_mem[rptr_q];
	assign rd_seq   = seq_mem[rptr_q];
	assign rd_start = start_mem[rptr_q];
	assign rd_count = count_mem[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctl_mem[wptr_q]   <= wr_ctl;
			seq_mem[wptr_q]   <= wr_seq;
			start_mem[wptr_q] <= wr_start;
			count_mem[wptr_q] <= wr_count;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/dlrs_back.sv =====
// Back end: expands each command into result beats, one per cycle while there
// is room, and holds them in a small result queue. Depends on dlrs_pkg.
module dlrs_back import dlrs_pkg::*; #(
	parameter int KeyBytes = KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_empty,
	input  cmd_ctl_t                      cmd_ctl,
	input  logic [KeyBytes:0][7:0]        cmd_seq,
	input  logic [$clog2(KeyBytes+1)-1:0] cmd_start,
	input  logic [$clog2(KeyBytes+1)-1:0] cmd_count,
	output logic                          cmd_pop,
	input  logic                          pop,
	output logic                          empty,
	output result_t                       result,
	output back_stat_t                    stat
);

	localparam int CW = $clog2(KeyBytes + 1);
	localparam int PW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int NW = $clog2(RESQ_DEPTH + 1);

	seg_t          seg_q, seg_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] rem_q, rem_d;

	seg_t          cur_seg;
	logic [CW-1:0] cur_idx;
	logic [CW-1:0] cur_rem;
	logic          done;
	logic          step;
	result_t       res_new;

	result_t       res_mem [RESQ_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;
	logic          res_full;
	logic          res_pop;

	assign res_full = (cnt_q == NW'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign res_pop  = pop && !empty;
	assign step     = !cmd_empty && !res_full;
	assign cmd_pop  = step && done;
	assign result   = res_mem[rptr_q];
	assign stat     = '{res_push: step, res_last: res_new.last, res_full: res_full};

	// Segment being emitted this cycle and whether it closes the command.
	always_comb begin
		if (seg_q == SEG_NEW) begin
			if (cmd_ctl.lead_valid) begin
				cur_seg = SEG_LEAD;
			end else if (cmd_count != '0) begin
				cur_seg = SEG_POPS;
			end else begin
				cur_seg = SEG_TAIL;
			end
			cur_idx = cmd_start;
			cur_rem = cmd_count;
		end else begin
			cur_seg = seg_q;
			cur_idx = idx_q;
			cur_rem = rem_q;
		end
		case (cur_seg)
			SEG_LEAD: done = (cmd_count == '0) && !cmd_ctl.tail_valid;
			SEG_POPS: done = (cur_rem <= CW'(1)) && !cmd_ctl.tail_valid;
			default:  done = 1'b1;
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		seg_d = seg_q;
		idx_d = idx_q;
		rem_d = rem_q;
		if (step) begin
			if (done) begin
				seg_d = SEG_NEW;
			end else begin
				case (cur_seg)
					SEG_LEAD: begin
						if (cmd_count != '0) begin
							seg_d = SEG_POPS;
							idx_d = cmd_start;
							rem_d = cmd_count;
						end else begin
							seg_d = SEG_TAIL;
						end
					end
					SEG_POPS: begin
						if (cur_rem > CW'(1)) begin
							seg_d = SEG_POPS;
							idx_d = cur_idx + CW'(1);
							rem_d = cur_rem - CW'(1);
						end else begin
							seg_d = SEG_TAIL;
						end
					end
					default: seg_d = SEG_NEW;
				endcase
			end
		end
	end

	// Result beat for the current segment.
	always_comb begin
		res_new.last = done;
		case (cur_seg)
			SEG_LEAD: begin
				res_new.data = cmd_ctl.lead_byte;
				res_new.kind = cmd_ctl.lead_kind;
				res_new.dir  = cmd_ctl.lead_dir;
			end
			SEG_POPS: begin
				res_new.data = cmd_seq[cur_idx];
				res_new.kind = KIND_BODY_BYTE;
				res_new.dir  = 1'b0;
			end
			default: begin
				res_new.data = 8'h00;
				res_new.kind = cmd_ctl.tail_kind;
				res_new.dir  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_NEW;
			idx_q <= '0;
			rem_q <= '0;
		end else begin
			seg_q <= seg_d;
			idx_q <= idx_d;
			rem_q <= rem_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (step) begin
			res_mem[wptr_q] <= res_new;
		end
	end

	// Result queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (step) begin
				wptr_q <= (wptr_q == PW'(RESQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (res_pop) begin
				rptr_q <= (rptr_q == PW'(RESQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			case ({step, res_pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/delimiter_record_splitter.sv =====
// Top level of the record splitter: front end, command queue and back end.
// Depends on dlrs_pkg, dlrs_front, dlrs_cmdq, dlrs_back and assert_macros.svh.
//
//   Channel   Handshake          Beat contents
//   input     push / full        data_byte, end_of_stream
//   result    empty / pop        out_byte, kind, is_directory, last
//   config    cfg_wr_en          cfg_index, cfg_data (64 bits)
//
// One input beat is taken per cycle while full is low; the front end decides
// everything about a byte in that cycle, including the parallel key compare.
// The back end emits one result beat per cycle while the result queue has
// room, so a beat that causes n results holds the back end until all n are
// out (up to seventeen for a stream end that flushes a full window); full
// rises when the two-entry command queue fills behind it. A result reaches
// the ports through the command queue register and then the result queue.
// Reset is asynchronous: phase, fill count and queues clear at once, the key
// length returns to one and the key to zero; there is no clearing pass.
`include "assert_macros.svh"
module delimiter_record_splitter import dlrs_pkg::*; #(
	parameter int KeyBytes = KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_stream,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             out_byte,
	output logic [2:0]             kind,
	output logic                   is_directory,
	output logic                   last,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(KeyBytes + 1);

	logic                   in_take;
	logic                   cmd_push;
	cmd_ctl_t               wr_ctl, rd_ctl;
	logic [KeyBytes:0][7:0] wr_seq, rd_seq;
	logic [CW-1:0]          wr_start, rd_start;
	logic [CW-1:0]          wr_count, rd_count;
	logic                   cmd_full;
	logic                   cmd_empty;
	logic                   cmd_pop;
	result_t                result;
	back_stat_t             stat;

	assign full    = cmd_full;
	assign in_take = push && !cmd_full;

	// Front end: classification and key window.
	dlrs_front #(.KeyBytes(KeyBytes)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_take      (in_take),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.cmd_push     (cmd_push),
		.cmd_ctl      (wr_ctl),
		.cmd_seq      (wr_seq),
		.cmd_start    (wr_start),
		.cmd_count    (wr_count)
	);

	// Command queue decoupling the two halves.
	dlrs_cmdq #(.KeyBytes(KeyBytes)) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_ctl  (wr_ctl),
		.wr_seq  (wr_seq),
		.wr_start(wr_start),
		.wr_count(wr_count),
		.rd_en   (cmd_pop),
		.rd_ctl  (rd_ctl),
		.rd_seq  (rd_seq),
		.rd_start(rd_start),
		.rd_count(rd_count),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	// Back end: result sequencing and result queue.
	dlrs_back #(.KeyBytes(KeyBytes)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_ctl  (rd_ctl),
		.cmd_seq  (rd_seq),
		.cmd_start(rd_start),
		.cmd_count(rd_count),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.stat     (stat)
	);

	assign out_byte     = result.data;
	assign kind         = result.kind;
	assign is_directory = result.dir;
	assign last         = result.last;

	// A command leaves the queue only together with its final result beat.
	`DLRS_ASSERT_IMP(a_pop_on_last, clk, arst_n, cmd_pop, stat.res_push && stat.res_last)
	// The back end never idles while it has work and room for a result.
	`DLRS_ASSERT_IMP(a_back_busy, clk, arst_n, !cmd_empty && !stat.res_full, stat.res_push)
	// The result queue stays empty unless the back end wrote to it.
	`DLRS_ASSERT_NEXT(a_empty_holds, clk, arst_n, empty && !stat.res_push, empty)
	// Every accepted stream end produces a command.
	`DLRS_ASSERT_IMP(a_eos_cmd, clk, arst_n, in_take && end_of_stream, cmd_push)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the delimiter record splitter.
// Depends on dlrs_pkg and delimiter_record_splitter; a built-in predictor computes each result.
module tb_top import dlrs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_BYTES = KEY_BYTES_DEF;
	localparam int HOLD_CYCLES = 250;
	localparam int PHASE_BEATS = 55;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [7:0]             data_byte;
	logic                   end_of_stream;
	logic                   empty;
	logic                   pop;
	logic [7:0]             out_byte;
	logic [2:0]             kind;
	logic                   is_directory;
	logic                   last;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	delimiter_record_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.kind         (kind),
		.is_directory (is_directory),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Predictor copy of the key registers and of the splitter state.
	logic [4:0]  cfg_key_len;
	logic [63:0] cfg_key_lo;
	logic [63:0] cfg_key_hi;
	phase_t      split_phase;
	logic [7:0]  win [WIN_BYTES];
	int          win_fill;
	logic [7:0]  last_name;

	result_t beat_results [$];
	result_t pending_results [$];

	int  errors;
	int  beats_in;
	int  results_seen;
	int  full_waits;
	int  settings_used;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  calm;
	bit  hold_req;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#8_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic bit ws_byte(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic int key_span();
		int l;
		l = int'(cfg_key_len);
		if (l == 0) l = 1;
		if (l > WIN_BYTES) l = WIN_BYTES;
		return l;
	endfunction

	function automatic logic [7:0] key_at(input int k);
		logic [7:0] r;
		if (k < 8) r = cfg_key_lo[8*k +: 8];
		else if (k < 16) r = cfg_key_hi[8*(k-8) +: 8];
		else r = 8'h00;
		return r;
	endfunction

	function automatic void note_result(input logic [7:0] d, input kind_t k, input logic dir);
		result_t r;
		r.data = d;
		r.kind = k;
		r.dir = dir;
		r.last = 1'b0;
		beat_results.push_back(r);
	endfunction

	// The oldest window byte leaves as a body byte.
	function automatic void shift_out_oldest();
		int i;
		note_result(win[0], KIND_BODY_BYTE, 1'b0);
		for (i = 0; i < win_fill - 1; i++) win[i] = win[i+1];
		win_fill--;
	endfunction

	function automatic void clear_split();
		split_phase = PH_DROP;
		win_fill = 0;
		last_name = 8'h00;
	endfunction

	// Work out the results of one accepted input beat and queue them.
	function automatic void split_beat(input logic [7:0] b, input logic eos);
		int l;
		int i;
		bit hit;
		result_t r;
		beat_results.delete();
		if (eos) begin
			if (split_phase == PH_NAME) begin
				note_result(8'h00, KIND_NAME_END, last_name == BACKSLASH);
			end else if (split_phase == PH_BODY) begin
				while (win_fill > 0) shift_out_oldest();
			end
			note_result(8'h00, KIND_STREAM_END, 1'b0);
			clear_split();
		end else begin
			case (split_phase)
				PH_DROP: begin
					split_phase = PH_SKIP;
				end
				PH_SKIP: begin
					if (!ws_byte(b)) begin
						note_result(b, KIND_NAME_BYTE, 1'b0);
						last_name = b;
						split_phase = PH_NAME;
					end
				end
				PH_NAME: begin
					if (ws_byte(b)) begin
						note_result(8'h00, KIND_NAME_END, last_name == BACKSLASH);
						win_fill = 0;
						split_phase = PH_BODY;
					end else begin
						note_result(b, KIND_NAME_BYTE, 1'b0);
						last_name = b;
					end
				end
				default: begin
					l = key_span();
					if (win_fill >= WIN_BYTES) shift_out_oldest();
					win[win_fill] = b;
					win_fill++;
					while (win_fill > l) shift_out_oldest();
					if (win_fill == l) begin
						hit = 1'b1;
						for (i = 0; i < l; i++) if (win[i] != key_at(i)) hit = 1'b0;
						if (hit) begin
							note_result(8'h00, KIND_RECORD_END, 1'b0);
							win_fill = 0;
							last_name = 8'h00;
							split_phase = PH_DROP;
						end
					end
				end
			endcase
		end
		for (i = 0; i < beat_results.size(); i++) begin
			r = beat_results[i];
			r.last = (i == beat_results.size() - 1);
			pending_results.push_back(r);
		end
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
	endfunction

	function automatic logic [7:0] pick_name_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (ws_byte(b)) b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// Offer one input beat, with an optional idle burst first, and wait for acceptance.
	task automatic send_beat(input logic [7:0] b, input logic eos);
		int gap;
		if (!calm && ($urandom_range(0, 99) < send_idle_pct)) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (full) begin
			full_waits++;
			@(posedge clk);
		end
		split_beat(b, eos);
		beats_in++;
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_KEY_LENGTH: cfg_key_len = val[4:0];
			REG_KEY_LOW:    cfg_key_lo = val;
			REG_KEY_HIGH:   cfg_key_hi = val;
			default: ;
		endcase
	endtask

	// Load a key; the length word carries random upper bits that must be ignored.
	task automatic program_key(input logic [4:0] len, input logic [63:0] lo,
			input logic [63:0] hi, input bit spare);
		logic [63:0] v;
		v = rand64();
		v[4:0] = len;
		write_reg(REG_KEY_LENGTH, v);
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
		if (spare) write_reg(REG_SPARE, rand64());
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// One record with random content; a broken one stops partway through the key.
	task automatic send_record(input bit broken);
		int n;
		int i;
		int j;
		int l;
		int cut;
		logic [7:0] b;
		l = key_span();
		send_beat(8'($urandom_range(0, 255)), 1'b0);
		repeat ($urandom_range(0, 2)) send_beat(pick_space(), 1'b0);
		n = $urandom_range(1, 5);
		for (i = 0; i < n; i++) begin
			if ((i == n - 1) && ($urandom_range(0, 3) == 0)) b = BACKSLASH;
			else b = pick_name_byte();
			send_beat(b, 1'b0);
		end
		send_beat(pick_space(), 1'b0);
		n = $urandom_range(0, 8);
		for (i = 0; i < n; i++) begin
			if ((l > 1) && ($urandom_range(0, 4) == 0)) begin
				cut = $urandom_range(1, l - 1);
				for (j = 0; j < cut; j++) send_beat(key_at(j), 1'b0);
			end else begin
				send_beat(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		cut = broken ? $urandom_range(0, l - 1) : l;
		for (i = 0; i < cut; i++) send_beat(key_at(i), 1'b0);
		if (broken && $urandom_range(0, 1)) send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Reset key: one zero byte. Covers any separator value, skipped space,
	// a directory name and a body byte released by the key compare.
	task automatic test_default_key();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		send_beat(8'hFF, 1'b0);
		send_beat(8'h20, 1'b0);
		send_beat(8'h41, 1'b0);
		send_beat(BACKSLASH, 1'b0);
		send_beat(8'h09, 1'b0);
		send_beat(8'h33, 1'b0);
		send_beat(8'h00, 1'b0);
	endtask

	// Stream end while dropping, while skipping and inside a directory name.
	task automatic test_stream_end();
		send_beat(8'hFF, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h0D, 1'b0);
		send_beat(8'h00, 1'b1);
		send_beat(8'h7E, 1'b0);
		send_beat(BACKSLASH, 1'b0);
		send_beat(8'hAA, 1'b1);
	endtask

	// Key length lowered while the window holds body bytes, then a body flush.
	task automatic test_key_shrink();
		settle();
		program_key(5'd16, rand64(), rand64(), 1'b1);
		send_beat(8'h80, 1'b0);
		send_beat(8'h6B, 1'b0);
		send_beat(8'h0C, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h12, 1'b0);
		send_beat(8'h34, 1'b0);
		settle();
		program_key(5'd2, rand64(), rand64(), 1'b0);
		send_beat(8'h56, 1'b0);
		send_beat(8'h0A, 1'b1);
	endtask

	// Receiver holds off for a long stretch while a body streams in.
	task automatic test_backpressure();
		int i;
		logic [7:0] b;
		logic [63:0] lo;
		settle();
		lo = rand64();
		lo[7:0] = 8'hA5;
		program_key(5'd1, lo, rand64(), 1'b0);
		send_idle_pct = 0;
		hold_req = 1'b1;
		send_beat(8'h5A, 1'b0);
		send_beat(8'h70, 1'b0);
		send_beat(8'h20, 1'b0);
		for (i = 0; i < 40; i++) begin
			b = 8'($urandom_range(0, 255));
			while (b == 8'hA5) b = 8'($urandom_range(0, 255));
			send_beat(b, 1'b0);
		end
		send_beat(8'hA5, 1'b0);
		settle();
	endtask

	// One key setting followed by a block of random traffic.
	task automatic run_setting(input logic [4:0] len, input logic [63:0] lo,
			input logic [63:0] hi, input int sidle, input int ridle, input bit quiet);
		int target;
		int r;
		settle();
		program_key(len, lo, hi, 1'($urandom_range(0, 1)));
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		calm = quiet;
		target = beats_in + PHASE_BEATS;
		while (beats_in < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) send_record(1'b0);
			else if (r < 87) send_record(1'b1);
			else if (r < 97) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			else send_beat(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic test_random_settings();
		run_setting(5'd0, rand64(), rand64(), 25, 25, 1'b0);
		run_setting(5'd1, 64'h0, 64'h0, 0, 0, 1'b0);
		run_setting(5'd16, '1, '1, 15, 30, 1'b0);
		run_setting(5'd31, rand64(), rand64(), 30, 10, 1'b0);
		run_setting(5'($urandom_range(2, 15)), rand64(), rand64(), 20, 20, 1'b0);
		run_setting(5'd16, rand64(), rand64(), 0, 0, 1'b1);
	endtask

	// Result side: random stall bursts, the long hold-off, and the check of every beat.
	initial begin
		result_t want;
		int stall_left;
		int hold_count;
		stall_left = 0;
		hold_count = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				hold_count++;
				if (hold_count >= HOLD_CYCLES) begin
					hold_req = 1'b0;
					hold_count = 0;
				end
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (!calm && ($urandom_range(0, 99) < recv_idle_pct)) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: kind %0d, out_byte %02h",
						kind, out_byte);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						errors++;
					end
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (is_directory !== want.dir) begin
						$error("is_directory: expected %0b, got %0b", want.dir, is_directory);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						errors++;
					end
				end
			end
		end
	end

	// Main sequence: reset, directed tests, random traffic, drain and verdict.
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		end_of_stream = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		beats_in = 0;
		results_seen = 0;
		full_waits = 0;
		settings_used = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cfg_key_len = KEY_LENGTH_RESET;
		cfg_key_lo = '0;
		cfg_key_hi = '0;
		clear_split();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_key();
		test_stream_end();
		test_key_shrink();
		test_backpressure();
		test_random_settings();

		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d result beats from %0d input beats (%0d cycles held off by full).",
			results_seen, beats_in, full_waits);
		$display("Ran %0d key settings, from one byte to sixteen plus zero and oversized lengths.",
			settings_used);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/dlrs_pkg.sv
src/dlrs_front.sv
src/dlrs_cmdq.sv
src/dlrs_back.sv
src/delimiter_record_splitter.sv
dv/tb_top.sv
